>>> hdl/assert_macros.svh
// assertion macros shared by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/ept_pkg.sv
// shared types and constants of the expiring peer table
`timescale 1ns / 1ps
`default_nettype none

package ept_pkg;

	localparam int KEY_W = 48;
	localparam int DL_W  = 48;

	// all-ones deadline means no deadline
	localparam logic [DL_W-1:0] SENTINEL = {DL_W{1'b1}};
	// largest deadline an entry may hold
	localparam logic [DL_W-1:0] DL_MAX   = {{(DL_W-1){1'b1}}, 1'b0};

	typedef enum logic [1:0] {
		EV_NEW     = 2'd0,
		EV_EXPIRED = 2'd1,
		EV_NEAREST = 2'd2,
		EV_FULL    = 2'd3
	} event_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UWR,
		ST_ULOW,
		ST_SFIN
	} state_t;

endpackage

`default_nettype wire

>>> hdl/ept_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module ept_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 32
) (
	input  wire logic                                          clk,
	input  wire logic                                          we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                              wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> hdl/expiring_peer_table.sv
// top level of the expiring peer table
`timescale 1ns / 1ps
`default_nettype none

// Expiring peer table: up to TABLE_DEPTH (address, port) keys, each with a
// deadline in milliseconds. Keys and deadlines sit in one ram (96 bits per
// slot, one read and one write port, registered read); slot valid bits and the
// nearest deadline are flip-flops cleared by reset, so there is no clearing
// pass. func 0 looks up the key: a new key goes to the lowest free slot and is
// reported as event 0, a known key gets its deadline refreshed to now plus
// timeout (held below all ones), a full table drops the key as event 3, and if
// the new deadline is earlier than the nearest one event 2 reports it. func 1
// evicts every entry due at or before now, reporting each as event 1 in slot
// order, then reports the minimum remaining deadline as event 2, or clears the
// nearest deadline to all ones if the table ends up empty. Each item walks
// every slot through the single ram read port, one slot per cycle while no
// sweep eviction waits behind a stalled result, then drains the read pipeline
// and does the write-back and the report; a new item is accepted only once the
// last one is finished. in_stall is high from the cycle after acceptance until
// the item is finished; the result register lets the next item in while the
// last result still waits. last marks the final result of an item; an item may
// give no result at all.
module expiring_peer_table #(
	parameter int TABLE_DEPTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input item channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        func,
	input  wire logic [31:0] addr,
	input  wire logic [15:0] port,
	input  wire logic [31:0] timeout_ms,
	input  wire logic [47:0] now_ms,
	// result item channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       event_res,
	output logic [31:0]      out_addr,
	output logic [15:0]      out_port,
	output logic [47:0]      deadline_ms,
	output logic             last
);

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int MW = ept_pkg::KEY_W + ept_pkg::DL_W;
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	// control state
	ept_pkg::state_t state_q, state_d;

	// captured item
	logic                       func_q;
	logic [ept_pkg::KEY_W-1:0]  key_q;
	logic [ept_pkg::DL_W-1:0]   dl_q;
	logic [47:0]                now_q;

	// table state outside the ram
	logic [TABLE_DEPTH-1:0]     valid_q;
	logic [ept_pkg::DL_W-1:0]   nearest_q;

	// scan pipeline: issue counter and the slot whose data is on the ram output
	logic [CW-1:0]              iss_q;
	logic                       s1_v_s1;
	logic [IW-1:0]              idx_s1;

	// update lookup results
	logic                       hit_v_q;
	logic [IW-1:0]              hit_idx_q;
	logic                       free_v_q;
	logic [IW-1:0]              free_idx_q;

	// sweep: running minimum and one held eviction (its last flag is not known yet)
	logic [ept_pkg::DL_W-1:0]   best_q;
	logic                       hold_v_q;
	logic [ept_pkg::KEY_W-1:0]  hold_key_q;

	// result register
	logic                       out_valid_q;
	ept_pkg::event_t            out_ev_q;
	logic [ept_pkg::KEY_W-1:0]  out_key_q;
	logic [ept_pkg::DL_W-1:0]   out_dl_q;
	logic                       out_last_q;

	// ram interface
	logic                       mem_we;
	logic [IW-1:0]              mem_waddr;
	logic [MW-1:0]              mem_wdata;
	logic [IW-1:0]              mem_raddr;
	logic [MW-1:0]              mem_rdata;

	// combinational helpers
	logic [ept_pkg::KEY_W-1:0]  rd_key;
	logic [ept_pkg::DL_W-1:0]   rd_dl;
	logic                       slot_v;
	logic                       key_hit;
	logic                       expired;
	logic                       out_free;
	logic [48:0]                sum;
	logic [ept_pkg::DL_W-1:0]   dl_in;
	logic                       lower;
	logic                       scan_stall;
	logic                       issue;
	logic                       scan_done;
	logic                       s1_work;
	logic                       out_load;
	ept_pkg::event_t            out_ev_d;
	logic [ept_pkg::KEY_W-1:0]  out_key_d;
	logic [ept_pkg::DL_W-1:0]   out_dl_d;
	logic                       out_last_d;

	ept_ram #(
		.WIDTH(MW),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// datapath around the ram output
	always_comb begin
		rd_key   = mem_rdata[MW-1:ept_pkg::DL_W];
		rd_dl    = mem_rdata[ept_pkg::DL_W-1:0];
		slot_v   = valid_q[idx_s1];
		key_hit  = slot_v && (rd_key == key_q);
		expired  = slot_v && (rd_dl <= now_q);
		out_free = !out_valid_q || !out_stall;
		// deadline of an update, held one below the sentinel
		sum      = {1'b0, now_ms} + {17'b0, timeout_ms};
		dl_in    = (sum[48] || (sum[47:0] == ept_pkg::SENTINEL)) ? ept_pkg::DL_MAX : sum[47:0];
		lower    = nearest_q > dl_q;
	end

	// scan sequencing: a sweep eviction waits while the held one cannot leave
	always_comb begin
		scan_stall = (state_q == ept_pkg::ST_SCAN) && s1_v_s1 && func_q && expired
			&& hold_v_q && !out_free;
		issue      = (state_q == ept_pkg::ST_SCAN) && !scan_stall && (iss_q != DEPTH_C);
		scan_done  = (iss_q == DEPTH_C) && !s1_v_s1;
		s1_work    = (state_q == ept_pkg::ST_SCAN) && s1_v_s1 && !scan_stall;
		// on a stall the same slot is read again so its data stays on the output
		mem_raddr  = scan_stall ? idx_s1 : iss_q[IW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ept_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, ram write and result register load
	always_comb begin
		state_d    = state_q;
		in_stall   = 1'b1;
		mem_we     = 1'b0;
		mem_waddr  = hit_v_q ? hit_idx_q : free_idx_q;
		mem_wdata  = {key_q, dl_q};
		out_load   = 1'b0;
		out_ev_d   = ept_pkg::EV_NEW;
		out_key_d  = '0;
		out_dl_d   = '0;
		out_last_d = 1'b0;
		unique case (state_q)
			ept_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = ept_pkg::ST_SCAN;
				end
			end
			ept_pkg::ST_SCAN: begin
				// a new eviction pushes the held one out, which cannot be last
				if (s1_work && func_q && expired && hold_v_q) begin
					out_load  = 1'b1;
					out_ev_d  = ept_pkg::EV_EXPIRED;
					out_key_d = hold_key_q;
				end
				if (scan_done) begin
					state_d = func_q ? ept_pkg::ST_SFIN : ept_pkg::ST_UWR;
				end
			end
			ept_pkg::ST_UWR: begin
				priority if (hit_v_q) begin
					// refresh in place, nothing to report yet
					mem_we  = 1'b1;
					state_d = ept_pkg::ST_ULOW;
				end else if (free_v_q) begin
					if (out_free) begin
						mem_we     = 1'b1;
						out_load   = 1'b1;
						out_ev_d   = ept_pkg::EV_NEW;
						out_key_d  = key_q;
						out_last_d = !lower;
						state_d    = ept_pkg::ST_ULOW;
					end
				end else begin
					// table full: drop and flag
					if (out_free) begin
						out_load   = 1'b1;
						out_ev_d   = ept_pkg::EV_FULL;
						out_key_d  = key_q;
						out_last_d = 1'b1;
						state_d    = ept_pkg::ST_IDLE;
					end
				end
			end
			ept_pkg::ST_ULOW: begin
				if (!lower) begin
					state_d = ept_pkg::ST_IDLE;
				end else if (out_free) begin
					out_load   = 1'b1;
					out_ev_d   = ept_pkg::EV_NEAREST;
					out_dl_d   = dl_q;
					out_last_d = 1'b1;
					state_d    = ept_pkg::ST_IDLE;
				end
			end
			ept_pkg::ST_SFIN: begin
				priority if (hold_v_q) begin
					if (out_free) begin
						out_load   = 1'b1;
						out_ev_d   = ept_pkg::EV_EXPIRED;
						out_key_d  = hold_key_q;
						out_last_d = (best_q == ept_pkg::SENTINEL);
					end
				end else if (best_q == ept_pkg::SENTINEL) begin
					state_d = ept_pkg::ST_IDLE;
				end else if (out_free) begin
					out_load   = 1'b1;
					out_ev_d   = ept_pkg::EV_NEAREST;
					out_dl_d   = best_q;
					out_last_d = 1'b1;
					state_d    = ept_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ept_pkg::ST_IDLE;
			end
		endcase
	end

	// captured item, needs no reset
	always_ff @(posedge clk) begin
		if (state_q == ept_pkg::ST_IDLE && in_valid) begin
			func_q <= func;
			key_q  <= {addr, port};
			dl_q   <= dl_in;
			now_q  <= now_ms;
		end
	end

	// scan control and table flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			nearest_q  <= ept_pkg::SENTINEL;
			iss_q      <= '0;
			s1_v_s1    <= 1'b0;
			idx_s1     <= '0;
			hit_v_q    <= 1'b0;
			hit_idx_q  <= '0;
			free_v_q   <= 1'b0;
			free_idx_q <= '0;
			best_q     <= ept_pkg::SENTINEL;
			hold_v_q   <= 1'b0;
			hold_key_q <= '0;
		end else begin
			if (state_q == ept_pkg::ST_IDLE && in_valid) begin
				iss_q    <= '0;
				s1_v_s1  <= 1'b0;
				hit_v_q  <= 1'b0;
				free_v_q <= 1'b0;
				hold_v_q <= 1'b0;
				best_q   <= ept_pkg::SENTINEL;
			end
			if (state_q == ept_pkg::ST_SCAN && !scan_stall) begin
				s1_v_s1 <= issue;
				idx_s1  <= iss_q[IW-1:0];
				if (issue) begin
					iss_q <= iss_q + CW'(1);
				end
			end
			// slot on the ram output
			if (s1_work) begin
				if (func_q) begin
					if (expired) begin
						valid_q[idx_s1] <= 1'b0;
						hold_v_q        <= 1'b1;
						hold_key_q      <= rd_key;
					end else if (slot_v && rd_dl < best_q) begin
						best_q <= rd_dl;
					end
				end else begin
					if (key_hit && !hit_v_q) begin
						hit_v_q   <= 1'b1;
						hit_idx_q <= idx_s1;
					end
					if (!slot_v && !free_v_q) begin
						free_v_q   <= 1'b1;
						free_idx_q <= idx_s1;
					end
				end
			end
			// insert claims the free slot
			if (state_q == ept_pkg::ST_UWR && !hit_v_q && free_v_q && out_free) begin
				valid_q[free_idx_q] <= 1'b1;
			end
			if (state_q == ept_pkg::ST_ULOW && lower && out_free) begin
				nearest_q <= dl_q;
			end
			if (state_q == ept_pkg::ST_SFIN) begin
				nearest_q <= best_q;
				if (hold_v_q && out_free) begin
					hold_v_q <= 1'b0;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_ev_q   <= out_ev_d;
			out_key_q  <= out_key_d;
			out_dl_q   <= out_dl_d;
			out_last_q <= out_last_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign event_res   = out_ev_q;
	assign out_addr    = out_key_q[47:16];
	assign out_port    = out_key_q[15:0];
	assign deadline_ms = out_dl_q;
	assign last        = out_last_q;

endmodule

`default_nettype wire

>>> hdl/ept_checker.sv
// port-level checker of the expiring peer table and its bind
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ept_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [1:0]  event_res,
	input wire logic [31:0] out_addr,
	input wire logic [15:0] out_port,
	input wire logic [47:0] deadline_ms,
	input wire logic        last
);

	`ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(event_res) && $stable(out_addr) && $stable(out_port) && $stable(deadline_ms) && $stable(last), "stalled result changed")
	`ASSERT_IMP(a_nearest_no_key, clk, arst_n, out_valid && event_res == ept_pkg::EV_NEAREST, out_addr == 32'd0 && out_port == 16'd0, "nearest deadline item carries a key")
	`ASSERT_IMP(a_nearest_real, clk, arst_n, out_valid && event_res == ept_pkg::EV_NEAREST, deadline_ms != ept_pkg::SENTINEL, "nearest deadline reported as sentinel")
	`ASSERT_IMP(a_key_no_dl, clk, arst_n, out_valid && event_res != ept_pkg::EV_NEAREST, deadline_ms == 48'd0, "key item carries a deadline")
	`ASSERT_IMP(a_full_last, clk, arst_n, out_valid && event_res == ept_pkg::EV_FULL, last, "table full drop not last")

endmodule

bind expiring_peer_table ept_checker u_ept_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.event_res  (event_res),
	.out_addr   (out_addr),
	.out_port   (out_port),
	.deadline_ms(deadline_ms),
	.last       (last)
);

`default_nettype wire

>>> verif/expiring_peer_table_tb.sv
// testbench of the expiring peer table: directed rows, then random items checked against an aging model
`timescale 1ns / 1ps

module expiring_peer_table_tb;

	localparam int TABLE_DEPTH    = 32;
	localparam int WATCHDOG_LIMIT = 2000;
	// keys that random items draw from, more than the table holds so it fills
	localparam int POOL_SIZE      = 48;
	// random items per idling phase, after the fill burst
	localparam int PHASE_ITEMS    = 72;
	// one burst inserts enough distinct keys to overflow the table
	localparam int BURST_ITEMS    = TABLE_DEPTH + 2;

	localparam logic FUNC_UPDATE = 1'b0;
	localparam logic FUNC_SWEEP  = 1'b1;

	// directed row whose results come from the predictor, not from the row
	localparam int CHECK_BY_MODEL = -1;

	typedef struct {
		logic        func;
		logic [31:0] addr;
		logic [15:0] port;
		logic [31:0] timeout;
		logic [47:0] now;
	} peer_item_t;

	typedef struct {
		ept_pkg::event_t ev;
		logic [31:0]     addr;
		logic [15:0]     port;
		logic [47:0]     dl;
		logic            last;
	} peer_report_t;

	// typed rows: up to two results, a key event and then a nearest deadline
	typedef struct {
		peer_item_t      item;
		int              typed;
		ept_pkg::event_t ev0;
		logic [31:0]     a0;
		logic [15:0]     p0;
		logic [47:0]     d1;
	} directed_row_t;

	// dut ports
	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_stall;
	logic        func        = 1'b0;
	logic [31:0] addr        = '0;
	logic [15:0] port        = '0;
	logic [31:0] timeout_ms  = '0;
	logic [47:0] now_ms      = '0;
	logic        out_valid;
	logic        out_stall   = 1'b0;
	logic [1:0]  event_res;
	logic [31:0] out_addr;
	logic [15:0] out_port;
	logic [47:0] deadline_ms;
	logic        last;

	// aging model of the table
	logic        peer_valid [TABLE_DEPTH];
	logic [47:0] peer_key [TABLE_DEPTH];
	logic [47:0] peer_deadline [TABLE_DEPTH];
	logic [47:0] nearest_dl;

	peer_report_t  item_reports[$];
	peer_report_t  due_reports[$];
	directed_row_t directed_rows[$];

	logic [31:0] pool_addr [POOL_SIZE];
	logic [15:0] pool_port [POOL_SIZE];
	logic [47:0] sim_now;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatch_count = 0;
	int idle_cycles = 0;

	expiring_peer_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.addr(addr),
		.port(port),
		.timeout_ms(timeout_ms),
		.now_ms(now_ms),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.event_res(event_res),
		.out_addr(out_addr),
		.out_port(out_port),
		.deadline_ms(deadline_ms),
		.last(last)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		$display("%0t mismatch: %s", $realtime, what);
		mismatch_count++;
	endtask

	function automatic void stage_result(input ept_pkg::event_t ev, input logic [31:0] a,
			input logic [15:0] p, input logic [47:0] dl);
		peer_report_t r;
		r.ev = ev;
		r.addr = a;
		r.port = p;
		r.dl = dl;
		r.last = 1'b0;
		item_reports.push_back(r);
	endfunction

	// works out the results of one item and updates the model table
	function automatic void predict_peer_item(input peer_item_t it);
		logic [47:0] key;
		logic [47:0] dl;
		logic [47:0] best;
		logic [48:0] sum;
		int hit;
		int free_slot;
		item_reports.delete();
		if (it.func == FUNC_UPDATE) begin
			key = {it.addr, it.port};
			// deadline held one below the no-deadline sentinel
			sum = {1'b0, it.now} + {17'd0, it.timeout};
			dl = (sum > {1'b0, ept_pkg::DL_MAX}) ? ept_pkg::DL_MAX : sum[47:0];
			hit = -1;
			free_slot = -1;
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				if (peer_valid[i]) begin
					if (hit < 0 && peer_key[i] == key)
						hit = i;
				end else if (free_slot < 0) begin
					free_slot = i;
				end
			end
			if (hit >= 0) begin
				peer_deadline[hit] = dl;
			end else if (free_slot >= 0) begin
				peer_valid[free_slot] = 1'b1;
				peer_key[free_slot] = key;
				peer_deadline[free_slot] = dl;
				stage_result(ept_pkg::EV_NEW, it.addr, it.port, '0);
			end else begin
				// full table: key dropped, nearest deadline untouched
				stage_result(ept_pkg::EV_FULL, it.addr, it.port, '0);
			end
			// nearest deadline only ever lowered by an update
			if ((hit >= 0 || free_slot >= 0) && nearest_dl > dl) begin
				nearest_dl = dl;
				stage_result(ept_pkg::EV_NEAREST, '0, '0, dl);
			end
		end else begin
			best = ept_pkg::SENTINEL;
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				if (peer_valid[i]) begin
					if (peer_deadline[i] <= it.now) begin
						peer_valid[i] = 1'b0;
						stage_result(ept_pkg::EV_EXPIRED, peer_key[i][47:16],
							peer_key[i][15:0], '0);
					end else if (peer_deadline[i] < best) begin
						best = peer_deadline[i];
					end
				end
			end
			// survivors always reported, even when the minimum did not move
			nearest_dl = best;
			if (best != ept_pkg::SENTINEL)
				stage_result(ept_pkg::EV_NEAREST, '0, '0, best);
		end
	endfunction

	function automatic void add_row(input logic f, input logic [31:0] a, input logic [15:0] p,
			input logic [31:0] t, input logic [47:0] now, input int typed = CHECK_BY_MODEL,
			input ept_pkg::event_t ev0 = ept_pkg::EV_NEW, input logic [31:0] a0 = '0,
			input logic [15:0] p0 = '0, input logic [47:0] d1 = '0);
		directed_row_t row;
		row.item.func = f;
		row.item.addr = a;
		row.item.port = p;
		row.item.timeout = t;
		row.item.now = now;
		row.typed = typed;
		row.ev0 = ev0;
		row.a0 = a0;
		row.p0 = p0;
		row.d1 = d1;
		directed_rows.push_back(row);
	endfunction

	// drives one item from a falling edge, returns at the falling edge after acceptance;
	// row picks a directed row whose typed results replace the prediction
	task automatic push_item(input peer_item_t it, input int row);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		func       <= it.func;
		addr       <= it.addr;
		port       <= it.port;
		timeout_ms <= it.timeout;
		now_ms     <= it.now;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		// accepted at this edge: the model still moves on typed rows
		predict_peer_item(it);
		if (row >= 0 && directed_rows[row].typed != CHECK_BY_MODEL) begin
			item_reports.delete();
			if (directed_rows[row].typed >= 1)
				stage_result(directed_rows[row].ev0, directed_rows[row].a0,
					directed_rows[row].p0, '0);
			if (directed_rows[row].typed == 2)
				stage_result(ept_pkg::EV_NEAREST, '0, '0, directed_rows[row].d1);
		end
		if (item_reports.size() > 0)
			item_reports[item_reports.size() - 1].last = 1'b1;
		foreach (item_reports[i])
			due_reports.push_back(item_reports[i]);
		@(negedge clk);
	endtask

	// random item: mostly pool keys on a moving clock, some sweeps, some noise
	function automatic peer_item_t next_random_item();
		peer_item_t it;
		int unsigned pick;
		int unsigned slot;
		logic [31:0] hi;
		pick = $urandom_range(0, 99);
		slot = $urandom_range(0, POOL_SIZE - 1);
		sim_now = sim_now + 48'($urandom_range(0, 40));
		it.func = FUNC_UPDATE;
		it.addr = pool_addr[slot];
		it.port = pool_port[slot];
		it.timeout = $urandom_range(0, 4000);
		it.now = sim_now;
		if (pick < 14) begin
			it.func = FUNC_SWEEP;
		end else if (pick < 16) begin
			// clears the whole table
			it.func = FUNC_SWEEP;
			it.now = ept_pkg::DL_MAX;
		end else if (pick < 27) begin
			// noise: random key and time, full-range lifetime; some become sweeps
			it.addr = $urandom;
			it.port = 16'($urandom);
			it.timeout = $urandom;
			hi = $urandom;
			it.now = {hi[15:0], $urandom};
			if (it.now == ept_pkg::SENTINEL)
				it.now = ept_pkg::DL_MAX;
			if (pick >= 24)
				it.func = FUNC_SWEEP;
		end else if (pick < 30) begin
			// long lifetime on a known key
			it.timeout = $urandom;
		end
		return it;
	endfunction

	// receiver stalls
	always @(negedge clk)
		out_stall <= ($urandom_range(0, 99) < recv_idle_pct);

	// result checker
	always @(posedge clk) begin
		peer_report_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (due_reports.size() == 0) begin
				report_mismatch($sformatf("unexpected result ev %0d addr %h port %h dl %h last %b",
					event_res, out_addr, out_port, deadline_ms, last));
			end else begin
				want = due_reports.pop_front();
				if (event_res !== want.ev || out_addr !== want.addr || out_port !== want.port
						|| deadline_ms !== want.dl || last !== want.last)
					report_mismatch($sformatf(
						"got ev %0d addr %h port %h dl %h last %b, want %0d %h %h %h %b",
						event_res, out_addr, out_port, deadline_ms, last,
						want.ev, want.addr, want.port, want.dl, want.last));
			end
		end
	end

	// watchdog on cycles where neither side moves an item
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_stall === 1'b0)
				|| (out_valid === 1'b1 && out_stall === 1'b0)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("expiring_peer_table_tb failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		peer_item_t it;
		logic [31:0] r;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			peer_valid[i] = 1'b0;
			peer_key[i] = '0;
			peer_deadline[i] = '0;
		end
		nearest_dl = ept_pkg::SENTINEL;

		// distinct keys: from index 2 on, low port bits carry the pool index
		pool_addr[0] = '0;
		pool_port[0] = '0;
		pool_addr[1] = '1;
		pool_port[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++) begin
			r = $urandom;
			pool_addr[i] = $urandom;
			pool_port[i] = {r[9:0], 6'(i)};
		end

		// directed rows, starting from an empty table
		// sweep of an empty table gives nothing
		add_row(FUNC_SWEEP, '0, '0, '0, '0, 0);
		// first key, zero lifetime: new key and nearest deadline zero
		add_row(FUNC_UPDATE, '0, '0, '0, '0, 2, ept_pkg::EV_NEW, '0, '0, '0);
		// all-ones key, top time and lifetime: saturated deadline, nearest stays
		add_row(FUNC_UPDATE, '1, '1, '1, ept_pkg::DL_MAX, 1, ept_pkg::EV_NEW, '1, '1);
		// refresh to a later deadline never raises the nearest one
		add_row(FUNC_UPDATE, '0, '0, 32'd100, 48'd5, 0);
		// sweep with survivors only
		add_row(FUNC_SWEEP, '0, '0, '0, 48'd50);
		// deadline equal to now is evicted
		add_row(FUNC_SWEEP, '0, '0, '0, 48'd105);
		// now at the top of its range evicts the rest and leaves the table empty
		add_row(FUNC_SWEEP, '1, '1, '1, ept_pkg::DL_MAX, 1, ept_pkg::EV_EXPIRED, '1, '1);
		add_row(FUNC_UPDATE, 32'hAAAA_AAAA, 16'h5555, 32'd1000, '0);
		// same address, other port is a different key
		add_row(FUNC_UPDATE, 32'hAAAA_AAAA, 16'hAAAA, 32'd2000, '0);
		add_row(FUNC_UPDATE, 32'h5555_5555, 16'h5555, 32'hAAAA_AAAA, 48'h5555_5555_5555);
		// survivors report the same nearest deadline again
		add_row(FUNC_SWEEP, '0, '0, '0, 48'd10);
		// refresh that lowers the nearest deadline
		add_row(FUNC_UPDATE, 32'hAAAA_AAAA, 16'hAAAA, 32'd500, '0);
		add_row(FUNC_UPDATE, 32'hAAAA_AAAA, 16'h5555, 32'd3000, '0);
		// sum runs past 48 bits and saturates
		add_row(FUNC_UPDATE, 32'h1234_5678, 16'h9ABC, '1, 48'hFFFF_FFFF_0000);
		add_row(FUNC_UPDATE, '0, '0, '0, 48'hAAAA_AAAA_AAAA);
		add_row(FUNC_SWEEP, '0, '0, '0, 48'd500);
		add_row(FUNC_UPDATE, '0, '0, 32'd5, 48'h5555_5555_5555);
		// eviction of several entries in slot order
		add_row(FUNC_SWEEP, '0, '0, '0, ept_pkg::DL_MAX);
		add_row(FUNC_SWEEP, '0, '0, '0, '0, 0);

		// hold reset, then release it at a falling edge
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 11;
		recv_idle_pct = 51;
		foreach (directed_rows[i])
			push_item(directed_rows[i].item, i);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 11;
					recv_idle_pct = 51;
					sim_now = 48'($urandom_range(0, 1000));
				end
				1: begin
					// swap sides and run the clock near the top of the range
					send_idle_pct = 51;
					recv_idle_pct = 11;
					sim_now = 48'hFFFF_FFFF_8000;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
					sim_now = 48'($urandom_range(0, 1000));
				end
			endcase
			// empty the table, then fill it past full with distinct keys
			it.func = FUNC_SWEEP;
			it.addr = $urandom;
			it.port = 16'($urandom);
			it.timeout = $urandom;
			it.now = ept_pkg::DL_MAX;
			push_item(it, -1);
			for (int k = 0; k < BURST_ITEMS; k++) begin
				sim_now = sim_now + 48'($urandom_range(0, 20));
				it.func = FUNC_UPDATE;
				it.addr = pool_addr[k];
				it.port = pool_port[k];
				it.timeout = $urandom_range(0, 5000);
				it.now = sim_now;
				push_item(it, -1);
			end
			for (int k = 0; k < PHASE_ITEMS; k++)
				push_item(next_random_item(), -1);
		end
		in_valid <= 1'b0;

		// drain, then leave room for a stray result
		while (due_reports.size() != 0)
			@(posedge clk);
		repeat (TABLE_DEPTH + 8) @(posedge clk);
		if (mismatch_count == 0)
			$display("expiring_peer_table_tb passed");
		else
			$display("expiring_peer_table_tb failed");
		$finish;
	end

endmodule
